@@ design/magnetic_encoder_multiturn_tracker_top_defines.svh @@
// ----------------------------------------------------------------------------
// magnetic encoder multiturn tracker assertion macros
// shared checker helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef MAGNETIC_ENCODER_MULTITURN_TRACKER_TOP_DEFINES_SVH
`define MAGNETIC_ENCODER_MULTITURN_TRACKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while in reset
`define MMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmt assertion failed");
// next-cycle implication, disabled while in reset
`define MMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmt assertion failed");
`else
`define MMT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/mmt_pkg.sv @@
// ----------------------------------------------------------------------------
// mmt_pkg
// shared codes and constants of the multiturn encoder tracker
// ----------------------------------------------------------------------------
package mmt_pkg;

  // operation codes of an input transaction
  localparam logic OP_READ = 1'b0;
  localparam logic OP_ZERO = 1'b1;

  // configuration register indexes
  localparam logic CFG_STEPS_PER_REV = 1'b0;
  localparam logic CFG_INVERT        = 1'b1;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] SPR_RESET = 16'd3200;

  // turn geometry, as 14-bit signed delta values
  localparam logic signed [13:0] HALF_TURN = 14'sd2048;
  localparam logic signed [13:0] FULL_TURN = 14'sd4096;

  // tenths of a degree per turn and the turn resolution shift
  localparam logic [23:0]  TENTHS_PER_TURN = 24'd3600;
  localparam int unsigned  TURN_SHIFT      = 12;

  // status byte bit positions
  localparam int unsigned ST_DETECT_BIT = 5;
  localparam int unsigned ST_WEAK_BIT   = 4;
  localparam int unsigned ST_STRONG_BIT = 3;

  // how the position stage updates the position
  typedef enum logic [1:0] {
    POS_HOLD,
    POS_ORIGIN,
    POS_SCALE
  } pos_mode_t;

endpackage

@@ design/mmt_if.sv @@
// ----------------------------------------------------------------------------
// mmt channel interfaces
// valid/ready channels for sensor transactions and tracker results
// ----------------------------------------------------------------------------

// input channel: sensor read or zero command
interface mmt_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic               read_ok;
  logic [7:0]         status_byte;
  logic [7:0]         angle_high;
  logic [7:0]         angle_low;
  logic signed [31:0] zero_position;

  modport source (output valid, op, read_ok, status_byte, angle_high, angle_low,
                  zero_position, input ready);
  modport sink (input valid, op, read_ok, status_byte, angle_high, angle_low,
                zero_position, output ready);
endinterface

// result channel: status, angle and multiturn position
interface mmt_out_if;
  logic               valid;
  logic               ready;
  logic               online;
  logic               valid_res;
  logic               magnet_found;
  logic               magnet_weak;
  logic               magnet_strong;
  logic [11:0]        angle_count;
  logic [11:0]        angle_tenths;
  logic signed [31:0] turn_counts;
  logic signed [31:0] position_out;
  logic [31:0]        error_count;

  modport source (output valid, online, valid_res, magnet_found, magnet_weak,
                  magnet_strong, angle_count, angle_tenths, turn_counts, position_out,
                  error_count, input ready);
  modport sink (input valid, online, valid_res, magnet_found, magnet_weak,
                magnet_strong, angle_count, angle_tenths, turn_counts, position_out,
                error_count, output ready);
endinterface

@@ design/magnetic_encoder_multiturn_tracker_top.sv @@
// ----------------------------------------------------------------------------
// magnetic encoder multiturn tracker
// two register stages: stage one updates the tracker state, stage two does the
// counts-to-steps multiply into the output register, which loads once free
// throughput: one transaction per cycle while the output register can drain;
// an accepted transaction waits in stage one until the output register is free
// reset: synchronous, clears all state; steps per rev returns to 3200
// ----------------------------------------------------------------------------
`include "magnetic_encoder_multiturn_tracker_top_defines.svh"

module magnetic_encoder_multiturn_tracker_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mmt_in_if.sink                                in_ch,
  mmt_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [mmt_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [mmt_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned PW = CW + 16;

  // configuration registers
  logic [15:0] spr_r;
  logic        inv_r;

  // tracker state, also the stage one payload
  logic [11:0]         prev_angle_r, prev_angle_nxt;
  logic                have_sample_r, have_sample_nxt;
  logic [31:0]         origin_r, origin_nxt;
  logic [CW-1:0]       accum_r, accum_nxt;
  logic                online_r, online_nxt;
  logic                valid_r, valid_nxt;
  logic                detect_r, detect_nxt;
  logic                weak_r, weak_nxt;
  logic                strong_r, strong_nxt;
  logic [11:0]         last_angle_r, last_angle_nxt;
  logic [11:0]         tenths_r, tenths_nxt;
  logic [31:0]         fail_r, fail_nxt;
  mmt_pkg::pos_mode_t  mode_r, mode_nxt;
  logic [CW-1:0]       mag_r;
  logic                neg_r;
  logic                a_v_r;

  // output register
  logic                out_v_r;
  logic                o_online_r, o_valid_r, o_detect_r, o_weak_r, o_strong_r;
  logic [11:0]         o_angle_r, o_tenths_r;
  logic [31:0]         o_counts_r, o_pos_r, o_fail_r;
  logic [31:0]         pos_nxt;

  // handshake
  logic in_acc, a_ready, b_ready, b_load;

  logic [11:0]         raw;
  logic [23:0]         tprod;
  logic signed [13:0]  diff, dwrap, dsel;
  logic                rd_valid;
  logic [PW-1:0]       prod, shifted;
  logic [31:0]         q32;

  assign b_ready     = !out_v_r || out_ch.ready;
  assign a_ready     = !a_v_r || b_ready;
  assign in_ch.ready = a_ready;
  assign in_acc      = in_ch.valid && a_ready;
  assign b_load      = a_v_r && b_ready;

  // configuration writes, zero steps per rev is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r <= mmt_pkg::SPR_RESET;
      inv_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mmt_pkg::CFG_STEPS_PER_REV: begin
          if (cfg_wdata != '0) spr_r <= cfg_wdata;
        end
        mmt_pkg::CFG_INVERT: inv_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // decode of the incoming read
  assign raw      = {in_ch.angle_high[3:0], in_ch.angle_low};
  assign tprod    = 24'(raw) * mmt_pkg::TENTHS_PER_TURN;
  assign rd_valid = in_ch.status_byte[mmt_pkg::ST_DETECT_BIT]
                 && !in_ch.status_byte[mmt_pkg::ST_WEAK_BIT]
                 && !in_ch.status_byte[mmt_pkg::ST_STRONG_BIT];

  // unwrap the angle change across one turn
  always_comb begin
    diff = $signed({2'b00, raw}) - $signed({2'b00, prev_angle_r});
    if (diff > mmt_pkg::HALF_TURN) begin
      dwrap = diff - mmt_pkg::FULL_TURN;
    end else if (diff < -mmt_pkg::HALF_TURN) begin
      dwrap = diff + mmt_pkg::FULL_TURN;
    end else begin
      dwrap = diff;
    end
    dsel = inv_r ? -dwrap : dwrap;
  end

  // state update for one transaction
  always_comb begin
    prev_angle_nxt  = prev_angle_r;
    have_sample_nxt = have_sample_r;
    origin_nxt      = origin_r;
    accum_nxt       = accum_r;
    online_nxt      = online_r;
    valid_nxt       = valid_r;
    detect_nxt      = detect_r;
    weak_nxt        = weak_r;
    strong_nxt      = strong_r;
    last_angle_nxt  = last_angle_r;
    tenths_nxt      = tenths_r;
    fail_nxt        = fail_r;
    mode_nxt        = mmt_pkg::POS_HOLD;
    unique case (in_ch.op)
      mmt_pkg::OP_ZERO: begin
        origin_nxt      = in_ch.zero_position;
        accum_nxt       = '0;
        mode_nxt        = mmt_pkg::POS_ORIGIN;
        have_sample_nxt = online_r && valid_r;
        if (online_r && valid_r) prev_angle_nxt = last_angle_r;
      end
      default: begin
        if (!in_ch.read_ok) begin
          online_nxt = 1'b0;
          valid_nxt  = 1'b0;
          fail_nxt   = fail_r + 32'd1;
        end else begin
          online_nxt     = 1'b1;
          valid_nxt      = rd_valid;
          detect_nxt     = in_ch.status_byte[mmt_pkg::ST_DETECT_BIT];
          weak_nxt       = in_ch.status_byte[mmt_pkg::ST_WEAK_BIT];
          strong_nxt     = in_ch.status_byte[mmt_pkg::ST_STRONG_BIT];
          last_angle_nxt = raw;
          tenths_nxt     = tprod[23:12];
          if (rd_valid) begin
            prev_angle_nxt  = raw;
            have_sample_nxt = 1'b1;
            if (!have_sample_r) begin
              mode_nxt = mmt_pkg::POS_ORIGIN;
            end else begin
              accum_nxt = accum_r + {{(CW-14){dsel[13]}}, dsel};
              mode_nxt  = mmt_pkg::POS_SCALE;
            end
          end
        end
      end
    endcase
  end

  // stage one: state registers and count magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r  <= '0;
      have_sample_r <= 1'b0;
      origin_r      <= '0;
      accum_r       <= '0;
      online_r      <= 1'b0;
      valid_r       <= 1'b0;
      detect_r      <= 1'b0;
      weak_r        <= 1'b0;
      strong_r      <= 1'b0;
      last_angle_r  <= '0;
      tenths_r      <= '0;
      fail_r        <= '0;
      mode_r        <= mmt_pkg::POS_HOLD;
      mag_r         <= '0;
      neg_r         <= 1'b0;
      a_v_r         <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_angle_r  <= prev_angle_nxt;
        have_sample_r <= have_sample_nxt;
        origin_r      <= origin_nxt;
        accum_r       <= accum_nxt;
        online_r      <= online_nxt;
        valid_r       <= valid_nxt;
        detect_r      <= detect_nxt;
        weak_r        <= weak_nxt;
        strong_r      <= strong_nxt;
        last_angle_r  <= last_angle_nxt;
        tenths_r      <= tenths_nxt;
        fail_r        <= fail_nxt;
        mode_r        <= mode_nxt;
        neg_r         <= accum_nxt[CW-1];
        mag_r         <= accum_nxt[CW-1] ? -accum_nxt : accum_nxt;
        a_v_r         <= 1'b1;
      end else if (b_ready) begin
        a_v_r <= 1'b0;
      end
    end
  end

  // stage two: counts to steps, truncated toward zero
  assign prod    = PW'(mag_r) * PW'(spr_r);
  assign shifted = prod >> mmt_pkg::TURN_SHIFT;
  assign q32     = shifted[31:0];

  always_comb begin
    unique case (mode_r)
      mmt_pkg::POS_ORIGIN: pos_nxt = origin_r;
      mmt_pkg::POS_SCALE:  pos_nxt = origin_r + (neg_r ? -q32 : q32);
      default:             pos_nxt = o_pos_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      o_pos_r    <= '0;
      o_online_r <= 1'b0;
      o_valid_r  <= 1'b0;
      o_detect_r <= 1'b0;
      o_weak_r   <= 1'b0;
      o_strong_r <= 1'b0;
      o_angle_r  <= '0;
      o_tenths_r <= '0;
      o_counts_r <= '0;
      o_fail_r   <= '0;
    end else begin
      if (b_load) begin
        out_v_r    <= 1'b1;
        o_pos_r    <= pos_nxt;
        o_online_r <= online_r;
        o_valid_r  <= valid_r;
        o_detect_r <= detect_r;
        o_weak_r   <= weak_r;
        o_strong_r <= strong_r;
        o_angle_r  <= last_angle_r;
        o_tenths_r <= tenths_r;
        o_counts_r <= 32'({32'd0, accum_r});
        o_fail_r   <= fail_r;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.online        = o_online_r;
  assign out_ch.valid_res     = o_valid_r;
  assign out_ch.magnet_found  = o_detect_r;
  assign out_ch.magnet_weak   = o_weak_r;
  assign out_ch.magnet_strong = o_strong_r;
  assign out_ch.angle_count   = o_angle_r;
  assign out_ch.angle_tenths  = o_tenths_r;
  assign out_ch.turn_counts   = o_counts_r;
  assign out_ch.position_out  = o_pos_r;
  assign out_ch.error_count   = o_fail_r;

  // failed read bumps the error count by one
  `MMT_ASSERT_NEXT(a_fail_cnt, clk, rst_n,
    in_acc && rst_n && in_ch.op == mmt_pkg::OP_READ && !in_ch.read_ok,
    fail_r == $past(fail_r) + 32'd1)

  // zero command clears counts and loads the origin
  `MMT_ASSERT_NEXT(a_zero_load, clk, rst_n,
    in_acc && rst_n && in_ch.op == mmt_pkg::OP_ZERO,
    accum_r == '0 && origin_r == $past(in_ch.zero_position))

  // scaled position only follows a valid, referenced sample
  `MMT_ASSERT_SAME(a_scale_valid, clk, rst_n,
    a_v_r && mode_r == mmt_pkg::POS_SCALE,
    online_r && valid_r && have_sample_r)

  // an empty output register never blocks the input
  `MMT_ASSERT_SAME(a_no_block, clk, rst_n, !out_v_r, in_ch.ready)

endmodule

@@ verif/magnetic_encoder_multiturn_tracker_checker.sv @@
// ----------------------------------------------------------------------------
// multiturn tracker result checker
// watches the sensor and result channels and the register port, keeps its
// own copy of the tracker state, and compares every result transaction
// field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module magnetic_encoder_multiturn_tracker_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  mmt_in_if                              in_ch,
  mmt_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [mmt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mmt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        online;
    logic        valid_res;
    logic        found;
    logic        too_weak;
    logic        too_strong;
    logic [11:0] raw;
    logic [11:0] tenths;
    logic [31:0] counts;
    logic [31:0] position;
    logic [31:0] errors;
  } tracker_result_t;

  // register copies
  logic [15:0] spr;
  logic        invert;

  // tracker state copy
  logic [11:0] ref_angle;
  logic        have_ref;
  logic [31:0] origin;
  logic [31:0] counts;
  logic [31:0] position;
  logic [31:0] errors;
  logic [11:0] angle;
  logic [11:0] tenths;
  logic        f_online, f_valid, f_detect, f_weak, f_strong;

  tracker_result_t expected_q[$];
  int unsigned     fail_tally = 0;

  // advance the tracker copy by one transaction and queue its result
  function automatic void track_transaction(logic op, logic ok, logic [7:0] st,
                                            logic [7:0] hi, logic [7:0] lo,
                                            logic [31:0] zp);
    logic [11:0]     raw;
    int              delta;
    logic [31:0]     mag;
    logic [47:0]     prod;
    logic [31:0]     scaled;
    tracker_result_t r;
    raw = {hi[3:0], lo};
    if (op == mmt_pkg::OP_ZERO) begin
      origin   = zp;
      counts   = '0;
      position = zp;
      // last angle is the reference only if the last read was good
      have_ref = f_online && f_valid;
      if (have_ref) ref_angle = angle;
    end else if (!ok) begin
      f_online = 1'b0;
      f_valid  = 1'b0;
      errors   = errors + 32'd1;
    end else begin
      f_online = 1'b1;
      f_detect = st[mmt_pkg::ST_DETECT_BIT];
      f_weak   = st[mmt_pkg::ST_WEAK_BIT];
      f_strong = st[mmt_pkg::ST_STRONG_BIT];
      f_valid  = f_detect && !f_weak && !f_strong;
      angle    = raw;
      tenths   = 12'((24'(raw) * mmt_pkg::TENTHS_PER_TURN) >> mmt_pkg::TURN_SHIFT);
      if (f_valid) begin
        if (!have_ref) begin
          ref_angle = raw;
          have_ref  = 1'b1;
          position  = origin;
        end else begin
          // shortest way around the turn, exact half turn stays as is
          delta = int'(raw) - int'(ref_angle);
          if (delta > int'(mmt_pkg::HALF_TURN)) delta -= int'(mmt_pkg::FULL_TURN);
          else if (delta < -int'(mmt_pkg::HALF_TURN)) delta += int'(mmt_pkg::FULL_TURN);
          ref_angle = raw;
          if (invert) delta = -delta;
          counts = counts + 32'(delta);
          // scale the magnitude, truncating toward zero
          mag    = counts[31] ? -counts : counts;
          prod   = 48'(mag) * 48'(spr);
          scaled = 32'(prod >> mmt_pkg::TURN_SHIFT);
          if (counts[31]) scaled = -scaled;
          position = origin + scaled;
        end
      end
    end
    r.online     = f_online;
    r.valid_res  = f_valid;
    r.found      = f_detect;
    r.too_weak   = f_weak;
    r.too_strong = f_strong;
    r.raw        = angle;
    r.tenths     = tenths;
    r.counts     = counts;
    r.position   = position;
    r.errors     = errors;
    expected_q.push_back(r);
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    tracker_result_t want_r;
    if (!rst_n) begin
      spr       = mmt_pkg::SPR_RESET;
      invert    = 1'b0;
      ref_angle = '0;
      have_ref  = 1'b0;
      origin    = '0;
      counts    = '0;
      position  = '0;
      errors    = '0;
      angle     = '0;
      tenths    = '0;
      {f_online, f_valid, f_detect, f_weak, f_strong} = '0;
      expected_q.delete();
    end else begin
      // register writes, a zero steps per rev is dropped
      if (cfg_we) begin
        if (cfg_addr == mmt_pkg::CFG_STEPS_PER_REV) begin
          if (cfg_wdata != '0) spr = cfg_wdata;
        end else if (cfg_addr == mmt_pkg::CFG_INVERT) begin
          invert = cfg_wdata[0];
        end
      end

      // result transaction against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no prediction pending");
          fail_tally++;
        end else begin
          want_r = expected_q.pop_front();
          check_field("online", want_r.online, out_ch.online);
          check_field("valid_res", want_r.valid_res, out_ch.valid_res);
          check_field("magnet_found", want_r.found, out_ch.magnet_found);
          check_field("magnet_weak", want_r.too_weak, out_ch.magnet_weak);
          check_field("magnet_strong", want_r.too_strong, out_ch.magnet_strong);
          check_field("angle_count", want_r.raw, out_ch.angle_count);
          check_field("angle_tenths", want_r.tenths, out_ch.angle_tenths);
          check_field("turn_counts", $signed(want_r.counts), out_ch.turn_counts);
          check_field("position_out", $signed(want_r.position), out_ch.position_out);
          check_field("error_count", want_r.errors, out_ch.error_count);
        end
      end

      // sensor transaction accepted
      if (in_ch.valid && in_ch.ready)
        track_transaction(in_ch.op, in_ch.read_ok, in_ch.status_byte,
                          in_ch.angle_high, in_ch.angle_low, in_ch.zero_position);
    end
    mismatches  <= fail_tally;
    outstanding <= expected_q.size();
  end

endmodule

@@ verif/magnetic_encoder_multiturn_tracker_top_test.sv @@
// ----------------------------------------------------------------------------
// multiturn tracker regression top
// drives sensor reads and zero commands through the tracker under several
// register settings, with random gaps on both channels; the checker beside
// the block predicts and compares every result
// ----------------------------------------------------------------------------
module magnetic_encoder_multiturn_tracker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 350;
  localparam logic [7:0]  ST_GOOD     = 8'(1 << mmt_pkg::ST_DETECT_BIT);

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [mmt_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [mmt_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int unsigned                    mismatches;
  int unsigned                    outstanding;
  int unsigned                    cycles = 0;
  bit                             steady_in = 1'b0;
  logic [11:0]                    walk_angle = '0;

  mmt_in_if  in_ch();
  mmt_out_if out_ch();

  magnetic_encoder_multiturn_tracker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  magnetic_encoder_multiturn_tracker_checker tracker_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure, calm stretches now and then
  initial begin
    int stall;
    int cyc;
    bit steady_out;
    stall = 0;
    cyc = 0;
    steady_out = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) steady_out = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (steady_out || $urandom_range(0, 99) >= 25) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end
    end
  end

  // one sensor transaction after a random gap
  task automatic send_transaction(logic op, logic ok, logic [7:0] st, logic [7:0] hi,
                                  logic [7:0] lo, logic [31:0] zp);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (steady_in || pick < 55) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.op            <= op;
    in_ch.read_ok       <= ok;
    in_ch.status_byte   <= st;
    in_ch.angle_high    <= hi;
    in_ch.angle_low     <= lo;
    in_ch.zero_position <= zp;
    in_ch.valid         <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [mmt_pkg::CFG_ADDR_W-1:0] addr,
                           logic [mmt_pkg::CFG_DATA_W-1:0] data);
    cfg_addr  <= addr;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly good reads walking around the turn, plus faults and zeroing
  task automatic run_phase(int count);
    int          pick;
    int          delta;
    logic [7:0]  st;
    logic [11:0] raw;
    logic [31:0] zp;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) steady_in = ($urandom_range(0, 3) == 0);
      if (n == count / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        case ($urandom_range(0, 3))
          0: zp = 32'h7FFF_FFFF - $urandom_range(0, 3);
          1: zp = 32'h8000_0000 + $urandom_range(0, 3);
          default: zp = $urandom;
        endcase
        send_transaction(mmt_pkg::OP_ZERO, 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), zp);
      end else if (pick < 11) begin
        send_transaction(mmt_pkg::OP_READ, 1'b0, 8'($urandom), 8'($urandom),
                         8'($urandom), $urandom);
      end else if (pick < 17) begin
        send_transaction(mmt_pkg::OP_READ, 1'b1, 8'($urandom), 8'($urandom),
                         8'($urandom), $urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) delta = ($urandom_range(0, 1) == 0) ? 2048 : -2048;
        else if (pick < 72) delta = int'($urandom_range(0, 80)) - 40;
        else if (pick < 92) delta = int'($urandom_range(0, 4094)) - 2047;
        else delta = $urandom_range(0, 4095);
        walk_angle = walk_angle + 12'(delta);
        raw = walk_angle;
        st = 8'($urandom);
        st[mmt_pkg::ST_DETECT_BIT] = 1'b1;
        st[mmt_pkg::ST_WEAK_BIT]   = 1'b0;
        st[mmt_pkg::ST_STRONG_BIT] = 1'b0;
        send_transaction(mmt_pkg::OP_READ, 1'b1, st, {4'($urandom), raw[11:8]},
                         raw[7:0], $urandom);
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_addr            <= mmt_pkg::CFG_STEPS_PER_REV;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= mmt_pkg::OP_READ;
    in_ch.read_ok       <= 1'b0;
    in_ch.status_byte   <= '0;
    in_ch.angle_high    <= '0;
    in_ch.angle_low     <= '0;
    in_ch.zero_position <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: faults, status decode, wrap-around and zeroing cases
    send_transaction(mmt_pkg::OP_READ, 1'b0, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_transaction(mmt_pkg::OP_READ, 1'b1, 8'h00, 8'hF0, 8'h00, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, 8'h38, 8'h0F, 8'hFF, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, 8'h30, 8'h01, 8'h23, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, 8'h28, 8'h04, 8'h56, '0);
    // first valid sample takes the origin
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h00, 8'h00, '0);
    // exact half turn both ways, then wrap across zero
    send_transaction(mmt_pkg::OP_READ, 1'b1, 8'hE7, 8'h08, 8'h00, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h00, 8'h00, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'hFF, 8'hFF, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h00, 8'h00, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h08, 8'h01, '0);
    // zero after a failed read waits for the next valid sample
    send_transaction(mmt_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, '0);
    send_transaction(mmt_pkg::OP_ZERO, 1'b0, 8'h00, 8'h00, 8'h00, 32'h7FFF_FFFF);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h00, 8'd100, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h04, 8'h4C, '0);
    // zero while valid keeps the last angle as reference
    send_transaction(mmt_pkg::OP_ZERO, 1'b1, 8'hFF, 8'hFF, 8'hFF, 32'h8000_0000);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h00, 8'd100, '0);
    send_transaction(mmt_pkg::OP_ZERO, 1'b0, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    // invalid read leaves counts alone
    send_transaction(mmt_pkg::OP_READ, 1'b1, 8'hFF, 8'hAB, 8'hCD, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h00, 8'h00, '0);
    send_transaction(mmt_pkg::OP_READ, 1'b1, ST_GOOD, 8'h07, 8'hFF, '0);
    send_transaction(mmt_pkg::OP_ZERO, 1'b0, 8'h00, 8'h00, 8'h00, '0);
    run_phase(PHASE_ITEMS);

    // smallest scale, inverted
    drain();
    write_reg(mmt_pkg::CFG_STEPS_PER_REV, 16'd1);
    write_reg(mmt_pkg::CFG_INVERT, 1'b1);
    run_phase(PHASE_ITEMS);

    // largest scale, forward
    drain();
    write_reg(mmt_pkg::CFG_STEPS_PER_REV, 16'hFFFF);
    write_reg(mmt_pkg::CFG_INVERT, 1'b0);
    run_phase(PHASE_ITEMS);

    // a zero scale write is dropped
    drain();
    write_reg(mmt_pkg::CFG_STEPS_PER_REV, 16'd0);
    write_reg(mmt_pkg::CFG_INVERT, 1'b1);
    run_phase(PHASE_ITEMS);

    // random scale and direction
    drain();
    write_reg(mmt_pkg::CFG_STEPS_PER_REV, 16'($urandom_range(1, 65535)));
    write_reg(mmt_pkg::CFG_INVERT, 1'($urandom));
    run_phase(PHASE_ITEMS);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mmt_pkg.sv
design/mmt_if.sv
design/magnetic_encoder_multiturn_tracker_top.sv
verif/magnetic_encoder_multiturn_tracker_checker.sv
verif/magnetic_encoder_multiturn_tracker_top_test.sv
